### hdl/abs_pkg.sv
// Shared types, codes and constants for the alternating-bit sender.
// Used by abs_csum, alternating_bit_sender_unit and the bench; depends on nothing.
package abs_pkg;

	localparam int FRAME_BYTES   = 20;
	localparam int PAYLOAD_BYTES = 20;
	localparam int FRAME_W       = 8 * FRAME_BYTES;
	localparam int SUM_W         = 13;
	localparam int HDR_SUM_W     = 11;

	typedef enum logic [1:0] {
		CMD_MSG     = 2'd0,
		CMD_ACK     = 2'd1,
		CMD_TIMEOUT = 2'd2,
		CMD_NONE    = 2'd3
	} abs_cmd_t;

	typedef enum logic [2:0] {
		ST_SENT       = 3'd0,
		ST_BUSY       = 3'd1,
		ST_CORRUPT    = 3'd2,
		ST_UNEXPECTED = 3'd3,
		ST_ACCEPTED   = 3'd4,
		ST_RESENT     = 3'd5
	} abs_status_t;

	typedef enum logic [1:0] {
		PH_IDLE0 = 2'd0,
		PH_WAIT0 = 2'd1,
		PH_IDLE1 = 2'd2,
		PH_WAIT1 = 2'd3
	} abs_phase_t;

	typedef struct packed {
		logic [1:0]         command;
		logic [63:0]        data_bytes_lo;
		logic [63:0]        data_bytes_mid;
		logic [31:0]        data_bytes_hi;
		logic signed [31:0] rx_seq_field;
		logic signed [31:0] rx_ack_field;
		logic signed [31:0] rx_check_field;
	} abs_in_t;

	typedef struct packed {
		abs_status_t        status;
		logic               tx_valid;
		logic               tx_seq_bit;
		logic [SUM_W-1:0]   tx_sum;
		logic [63:0]        tx_bytes_lo;
		logic [63:0]        tx_bytes_mid;
		logic [31:0]        tx_bytes_hi;
		logic               timer_start;
		logic               timer_stop;
	} abs_out_t;

endpackage

### hdl/abs_csum.sv
// Payload masking and byte-sum checksum terms for one incoming word.
// Depends on abs_pkg.
module abs_csum (
	input  abs_pkg::abs_in_t                 word,
	output logic [abs_pkg::FRAME_W-1:0]      payload,
	output logic [abs_pkg::SUM_W-1:0]        pay_sum,
	output logic [abs_pkg::HDR_SUM_W-1:0]    hdr_sum
);

	logic [abs_pkg::FRAME_W-1:0] raw;
	logic [9:0]                  grp_sum [abs_pkg::FRAME_BYTES/4];

	assign raw = {word.data_bytes_hi, word.data_bytes_mid, word.data_bytes_lo};

	// Bytes past the configured payload length are carried and summed as zero.
	always_comb begin
		for (int i = 0; i < abs_pkg::FRAME_BYTES; i++) begin
			if (i < abs_pkg::PAYLOAD_BYTES) begin
				payload[8*i +: 8] = raw[8*i +: 8];
			end else begin
				payload[8*i +: 8] = 8'd0;
			end
		end
	end

	// Two-level sum: four bytes per group, then the groups.
	always_comb begin
		for (int g = 0; g < abs_pkg::FRAME_BYTES/4; g++) begin
			grp_sum[g] = 10'(payload[32*g +: 8]) + 10'(payload[32*g+8 +: 8])
				+ 10'(payload[32*g+16 +: 8]) + 10'(payload[32*g+24 +: 8]);
		end
		pay_sum = '0;
		for (int g = 0; g < abs_pkg::FRAME_BYTES/4; g++) begin
			pay_sum = pay_sum + abs_pkg::SUM_W'(grp_sum[g]);
		end
	end

	assign hdr_sum =
		abs_pkg::HDR_SUM_W'(word.rx_seq_field[7:0]) + abs_pkg::HDR_SUM_W'(word.rx_seq_field[15:8])
		+ abs_pkg::HDR_SUM_W'(word.rx_seq_field[23:16]) + abs_pkg::HDR_SUM_W'(word.rx_seq_field[31:24])
		+ abs_pkg::HDR_SUM_W'(word.rx_ack_field[7:0]) + abs_pkg::HDR_SUM_W'(word.rx_ack_field[15:8])
		+ abs_pkg::HDR_SUM_W'(word.rx_ack_field[23:16]) + abs_pkg::HDR_SUM_W'(word.rx_ack_field[31:24]);

endmodule

### hdl/alternating_bit_sender_unit.sv
// Alternating-bit sender: each word is one event; every command but CMD_NONE is answered
// by one result word. An accepted event word passes through the input register, then the
// result register. It takes one word per cycle while res_ready keeps results moving.
// A result waiting on res_ready stalls the input once the input register is full.
// Reset clears the phase, the stored packet and both valid flags at once.
// Depends on abs_pkg and abs_csum.
module alternating_bit_sender_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_ready,
	input  abs_pkg::abs_in_t  cmd,
	output logic              res_valid,
	input  logic              res_ready,
	output abs_pkg::abs_out_t res
);

	logic                          valid_s1;
	abs_pkg::abs_cmd_t             command_s1;
	logic [abs_pkg::FRAME_W-1:0]   payload_s1;
	logic [abs_pkg::SUM_W-1:0]     pay_sum_s1;
	logic [abs_pkg::HDR_SUM_W-1:0] hdr_sum_s1;
	logic [31:0]                   rx_ack_s1;
	logic [31:0]                   rx_check_s1;

	logic [abs_pkg::FRAME_W-1:0]   payload_d;
	logic [abs_pkg::SUM_W-1:0]     pay_sum_d;
	logic [abs_pkg::HDR_SUM_W-1:0] hdr_sum_d;

	abs_pkg::abs_phase_t           phase_q, phase_d;
	logic                          saved_seq_q, saved_seq_d;
	logic [abs_pkg::FRAME_W-1:0]   saved_payload_q, saved_payload_d;
	logic [abs_pkg::SUM_W-1:0]     saved_sum_q, saved_sum_d;

	abs_pkg::abs_out_t             res_d;
	logic                          res_has_d;
	logic                          res_valid_q;
	abs_pkg::abs_out_t             res_q;

	logic                          advance;
	logic                          take_s1;
	logic [abs_pkg::SUM_W-1:0]     ack_sum;
	logic                          send_seq;

	abs_csum u_csum (
		.word    (cmd),
		.payload (payload_d),
		.pay_sum (pay_sum_d),
		.hdr_sum (hdr_sum_d)
	);

	assign advance   = !res_valid_q || res_ready;
	assign take_s1   = valid_s1 && advance;
	assign cmd_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_ready) begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_ready && cmd_valid) begin
			command_s1  <= abs_pkg::abs_cmd_t'(cmd.command);
			payload_s1  <= payload_d;
			pay_sum_s1  <= pay_sum_d;
			hdr_sum_s1  <= hdr_sum_d;
			rx_ack_s1   <= cmd.rx_ack_field;
			rx_check_s1 <= cmd.rx_check_field;
		end
	end

	assign ack_sum  = abs_pkg::SUM_W'(hdr_sum_s1) + pay_sum_s1;
	assign send_seq = (phase_q == abs_pkg::PH_IDLE1);

	always_comb begin
		phase_d         = phase_q;
		saved_seq_d     = saved_seq_q;
		saved_payload_d = saved_payload_q;
		saved_sum_d     = saved_sum_q;
		res_d           = '0;
		res_has_d       = 1'b1;
		case (command_s1)
			abs_pkg::CMD_MSG: begin
				if (phase_q inside {abs_pkg::PH_WAIT0, abs_pkg::PH_WAIT1}) begin
					res_d.status = abs_pkg::ST_BUSY;
				end else begin
					saved_seq_d     = send_seq;
					saved_payload_d = payload_s1;
					saved_sum_d     = pay_sum_s1 + abs_pkg::SUM_W'(send_seq);
					phase_d         = send_seq ? abs_pkg::PH_WAIT1 : abs_pkg::PH_WAIT0;
					res_d.status       = abs_pkg::ST_SENT;
					res_d.tx_valid     = 1'b1;
					res_d.tx_seq_bit   = send_seq;
					res_d.tx_sum       = saved_sum_d;
					res_d.tx_bytes_lo  = payload_s1[63:0];
					res_d.tx_bytes_mid = payload_s1[127:64];
					res_d.tx_bytes_hi  = payload_s1[159:128];
					res_d.timer_start  = 1'b1;
				end
			end
			abs_pkg::CMD_ACK: begin
				// Checksum test first, then phase, then the exact ack number.
				if (rx_check_s1 != {{(32-abs_pkg::SUM_W){1'b0}}, ack_sum}) begin
					res_d.status = abs_pkg::ST_CORRUPT;
				end else if (phase_q inside {abs_pkg::PH_IDLE0, abs_pkg::PH_IDLE1}) begin
					res_d.status = abs_pkg::ST_UNEXPECTED;
				end else if (rx_ack_s1 != {31'd0, phase_q == abs_pkg::PH_WAIT1}) begin
					res_d.status = abs_pkg::ST_UNEXPECTED;
				end else begin
					phase_d = (phase_q == abs_pkg::PH_WAIT0) ? abs_pkg::PH_IDLE1
						: abs_pkg::PH_IDLE0;
					res_d.status     = abs_pkg::ST_ACCEPTED;
					res_d.timer_stop = 1'b1;
				end
			end
			abs_pkg::CMD_TIMEOUT: begin
				res_d.status       = abs_pkg::ST_RESENT;
				res_d.tx_valid     = 1'b1;
				res_d.tx_seq_bit   = saved_seq_q;
				res_d.tx_sum       = saved_sum_q;
				res_d.tx_bytes_lo  = saved_payload_q[63:0];
				res_d.tx_bytes_mid = saved_payload_q[127:64];
				res_d.tx_bytes_hi  = saved_payload_q[159:128];
				res_d.timer_start  = 1'b1;
			end
			default: begin
				res_has_d = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= abs_pkg::PH_IDLE0;
			saved_seq_q     <= 1'b0;
			saved_payload_q <= '0;
			saved_sum_q     <= '0;
		end else if (take_s1) begin
			phase_q         <= phase_d;
			saved_seq_q     <= saved_seq_d;
			saved_payload_q <= saved_payload_d;
			saved_sum_q     <= saved_sum_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (take_s1 && res_has_d) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_s1 && res_has_d) begin
			res_q <= res_d;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	a_tx_matches_status: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q |-> (res_q.tx_valid == (res_q.status == abs_pkg::ST_SENT
			|| res_q.status == abs_pkg::ST_RESENT)))
		else $error("tx_valid disagrees with status");

	a_stop_only_on_accept: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.timer_stop |-> res_q.status == abs_pkg::ST_ACCEPTED)
		else $error("timer_stop without an accepted ack");

	a_sent_then_waiting: assert property (@(posedge clk) disable iff (!arst_n)
		take_s1 && res_has_d && res_d.status == abs_pkg::ST_SENT |=>
			(phase_q == abs_pkg::PH_WAIT0 || phase_q == abs_pkg::PH_WAIT1))
		else $error("phase not waiting after a send");

	a_phase_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!take_s1 |=> $stable(phase_q))
		else $error("phase changed without an event");

endmodule

### bench/alternating_bit_sender_unit_test.sv
// Self-checking bench for the alternating-bit sender: a directed table followed by
// phase-aware random events, each result word checked against the table's expected word
// or a local sender model. Depends on abs_pkg and the alternating_bit_sender_unit RTL.
module alternating_bit_sender_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	import abs_pkg::*;

	localparam int RANDOM_EVENTS = 1700;
	localparam int DRAIN_CYCLES  = 8;
	localparam int STALL_LIMIT   = 2000;
	localparam logic [FRAME_W-1:0] ALL_ONES = '1;
	localparam logic [FRAME_W-1:0] NO_DATA  = '0;

	typedef struct {
		abs_in_t  word;
		bit       typed;
		abs_out_t want;
	} stim_row_t;

	logic     clk;
	logic     arst_n;
	logic     cmd_valid;
	logic     cmd_ready;
	abs_in_t  cmd;
	logic     res_valid;
	logic     res_ready;
	abs_out_t res;

	// Local copy of the sender state.
	abs_phase_t         link_phase;
	logic               held_seq;
	logic [FRAME_W-1:0] held_frame;
	logic [SUM_W-1:0]   held_sum;

	abs_out_t  pending_results[$];
	stim_row_t directed_rows[$];
	int        errors;
	int        events_answered;
	int        acks_accepted;
	int        resends;
	int        send_idle_pct;
	int        stall_pct;
	int        quiet_cycles;

	alternating_bit_sender_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int unsigned word_byte_sum(logic [31:0] v);
		int unsigned s;
		s = 0;
		for (int i = 0; i < 4; i++)
			s += v[8*i +: 8];
		return s;
	endfunction

	function automatic int unsigned frame_sum(logic [FRAME_W-1:0] f);
		int unsigned s;
		s = 0;
		for (int i = 0; i < PAYLOAD_BYTES; i++)
			s += f[8*i +: 8];
		return s;
	endfunction

	// Bytes past the payload length are neither stored nor sent.
	function automatic logic [FRAME_W-1:0] frame_of(abs_in_t w);
		logic [FRAME_W-1:0] f;
		f = {w.data_bytes_hi, w.data_bytes_mid, w.data_bytes_lo};
		for (int i = PAYLOAD_BYTES; i < FRAME_BYTES; i++)
			f[8*i +: 8] = 8'h00;
		return f;
	endfunction

	function automatic int unsigned ack_checksum(abs_in_t w);
		return word_byte_sum(w.rx_seq_field) + word_byte_sum(w.rx_ack_field)
			+ frame_sum(frame_of(w));
	endfunction

	function automatic abs_in_t with_checksum(abs_in_t w);
		w.rx_check_field = ack_checksum(w);
		return w;
	endfunction

	function automatic abs_out_t stored_packet(abs_status_t s);
		abs_out_t r;
		r = '0;
		r.status       = s;
		r.tx_valid     = 1'b1;
		r.tx_seq_bit   = held_seq;
		r.tx_sum       = held_sum;
		r.tx_bytes_lo  = held_frame[63:0];
		r.tx_bytes_mid = held_frame[127:64];
		r.tx_bytes_hi  = held_frame[159:128];
		r.timer_start  = 1'b1;
		return r;
	endfunction

	// Advances the local sender state by one event word; returns 1 when it answers.
	function automatic bit predict_sender(input abs_in_t w, output abs_out_t r);
		r = '0;
		case (w.command)
			CMD_MSG: begin
				if (link_phase == PH_WAIT0 || link_phase == PH_WAIT1) begin
					r.status = ST_BUSY;
				end else begin
					held_seq   = (link_phase == PH_IDLE1);
					held_frame = frame_of(w);
					held_sum   = SUM_W'(frame_sum(held_frame) + held_seq);
					link_phase = held_seq ? PH_WAIT1 : PH_WAIT0;
					r = stored_packet(ST_SENT);
				end
			end
			CMD_ACK: begin
				if (ack_checksum(w) != unsigned'(w.rx_check_field)) begin
					r.status = ST_CORRUPT;
				end else if (link_phase == PH_IDLE0 || link_phase == PH_IDLE1) begin
					r.status = ST_UNEXPECTED;
				end else if (w.rx_ack_field != ((link_phase == PH_WAIT1) ? 1 : 0)) begin
					r.status = ST_UNEXPECTED;
				end else begin
					link_phase  = (link_phase == PH_WAIT0) ? PH_IDLE1 : PH_IDLE0;
					r.status    = ST_ACCEPTED;
					r.timer_stop = 1'b1;
				end
			end
			CMD_TIMEOUT: r = stored_packet(ST_RESENT);
			default: return 1'b0;
		endcase
		return 1'b1;
	endfunction

	function automatic logic [FRAME_W-1:0] random_frame();
		case ($urandom_range(9))
			0: return ALL_ONES;
			1: return NO_DATA;
			default: return {$urandom, $urandom, $urandom, $urandom, $urandom};
		endcase
	endfunction

	function automatic abs_in_t make_event(abs_cmd_t c, logic [FRAME_W-1:0] f,
		logic [31:0] sq, logic [31:0] ak, logic [31:0] ck);
		abs_in_t w;
		w.command        = c;
		w.data_bytes_lo  = f[63:0];
		w.data_bytes_mid = f[127:64];
		w.data_bytes_hi  = f[159:128];
		w.rx_seq_field   = sq;
		w.rx_ack_field   = ak;
		w.rx_check_field = ck;
		return w;
	endfunction

	function automatic abs_out_t typed_result(abs_status_t s, bit sent, bit seq, int sum,
		logic [FRAME_W-1:0] f, bit stop);
		abs_out_t r;
		r = '0;
		r.status = s;
		if (sent) begin
			r.tx_valid     = 1'b1;
			r.tx_seq_bit   = seq;
			r.tx_sum       = SUM_W'(sum);
			r.tx_bytes_lo  = f[63:0];
			r.tx_bytes_mid = f[127:64];
			r.tx_bytes_hi  = f[159:128];
			r.timer_start  = 1'b1;
		end
		r.timer_stop = stop;
		return r;
	endfunction

	// Mostly legal traffic for the current phase, with corrupt, misnumbered and stray words.
	function automatic abs_in_t random_event();
		abs_in_t     w;
		int unsigned pick;
		bit          waiting;
		pick    = $urandom_range(99);
		waiting = (link_phase == PH_WAIT0) || (link_phase == PH_WAIT1);
		w = make_event(CMD_ACK, random_frame(), $urandom,
			(link_phase == PH_WAIT1) ? 1 : 0, $urandom);
		if (pick < 8) begin
			w.command = abs_cmd_t'($urandom_range(3));
			if ($urandom_range(1))
				w.rx_ack_field = $urandom;
		end else if (waiting) begin
			if (pick < 55) begin
				w = with_checksum(w);
			end else if (pick < 70) begin
				w.command = CMD_TIMEOUT;
			end else if (pick < 78) begin
				w.command = CMD_MSG;
			end else if (pick < 84) begin
				w = with_checksum(w);
				w.rx_check_field = w.rx_check_field ^ (1 << $urandom_range(31));
			end else if (pick >= 88) begin
				if (pick[0])
					w.rx_ack_field = $urandom;
				else
					w.rx_ack_field = (link_phase == PH_WAIT1) ? 0 : 1;
				w = with_checksum(w);
			end
		end else begin
			if (pick < 70)
				w.command = CMD_MSG;
			else if (pick < 80)
				w.command = CMD_TIMEOUT;
			else if (pick < 92)
				w = with_checksum(w);
		end
		return w;
	endfunction

	task automatic add_row(input abs_in_t w, input bit typed, input abs_out_t want);
		stim_row_t row;
		row.word  = w;
		row.typed = typed;
		row.want  = want;
		directed_rows.push_back(row);
	endtask

	// Offers one event word and records what it should produce once it is taken.
	task automatic send_word(input abs_in_t w, input bit typed, input abs_out_t want);
		abs_out_t predicted;
		if ($urandom_range(99) < send_idle_pct) begin
			cmd_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
		cmd       <= w;
		cmd_valid <= 1'b1;
		do
			@(posedge clk);
		while (!cmd_ready);
		if (predict_sender(w, predicted)) begin
			pending_results.push_back(typed ? want : predicted);
			events_answered++;
			if (predicted.status == ST_ACCEPTED)
				acks_accepted++;
			if (predicted.status == ST_RESENT)
				resends++;
		end
	endtask

	task automatic drain_results();
		cmd_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic check_result(input abs_out_t got);
		abs_out_t want;
		if (pending_results.size() == 0) begin
			$error("result word with nothing pending: status %0d", got.status);
			errors++;
			return;
		end
		want = pending_results.pop_front();
		if (got.status !== want.status) begin
			$error("status: expected %0d, got %0d", want.status, got.status);
			errors++;
		end
		if (got.tx_valid !== want.tx_valid) begin
			$error("tx_valid: expected %0d, got %0d", want.tx_valid, got.tx_valid);
			errors++;
		end
		if (got.tx_seq_bit !== want.tx_seq_bit) begin
			$error("tx_seq_bit: expected %0d, got %0d", want.tx_seq_bit, got.tx_seq_bit);
			errors++;
		end
		if (got.tx_sum !== want.tx_sum) begin
			$error("tx_sum: expected %0d, got %0d", want.tx_sum, got.tx_sum);
			errors++;
		end
		if (got.tx_bytes_lo !== want.tx_bytes_lo) begin
			$error("tx_bytes_lo: expected %h, got %h", want.tx_bytes_lo, got.tx_bytes_lo);
			errors++;
		end
		if (got.tx_bytes_mid !== want.tx_bytes_mid) begin
			$error("tx_bytes_mid: expected %h, got %h", want.tx_bytes_mid, got.tx_bytes_mid);
			errors++;
		end
		if (got.tx_bytes_hi !== want.tx_bytes_hi) begin
			$error("tx_bytes_hi: expected %h, got %h", want.tx_bytes_hi, got.tx_bytes_hi);
			errors++;
		end
		if (got.timer_start !== want.timer_start) begin
			$error("timer_start: expected %0d, got %0d", want.timer_start, got.timer_start);
			errors++;
		end
		if (got.timer_stop !== want.timer_stop) begin
			$error("timer_stop: expected %0d, got %0d", want.timer_stop, got.timer_stop);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && res_valid && res_ready)
			check_result(res);
		res_ready <= ($urandom_range(99) >= stall_pct);
	end

	// Ends the run if neither channel moves a word for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd_valid && cmd_ready) || (res_valid && res_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	initial begin
		int  directed_answered;
		int  n;
		bit  held_off;
		clk             = 1'b0;
		arst_n          = 1'b0;
		cmd_valid       = 1'b0;
		cmd             = '0;
		res_ready       = 1'b0;
		errors          = 0;
		events_answered = 0;
		acks_accepted   = 0;
		resends         = 0;
		send_idle_pct   = 0;
		stall_pct       = 0;
		quiet_cycles    = 0;
		held_off        = 1'b0;
		link_phase      = PH_IDLE0;
		held_seq        = 1'b0;
		held_frame      = '0;
		held_sum        = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Idle after reset: a timeout resends the all-zero packet.
		add_row(make_event(CMD_TIMEOUT, NO_DATA, 0, 0, 0), 1,
			typed_result(ST_RESENT, 1, 0, 0, NO_DATA, 0));
		add_row(make_event(CMD_ACK, NO_DATA, 0, 0, 0), 1,
			typed_result(ST_UNEXPECTED, 0, 0, 0, NO_DATA, 0));
		add_row(make_event(CMD_ACK, NO_DATA, 0, 0, 1), 1,
			typed_result(ST_CORRUPT, 0, 0, 0, NO_DATA, 0));
		add_row(make_event(CMD_NONE, random_frame(), $urandom, $urandom, $urandom), 0, '0);
		add_row(make_event(CMD_MSG, ALL_ONES, $urandom, $urandom, $urandom), 1,
			typed_result(ST_SENT, 1, 0, 5100, ALL_ONES, 0));
		add_row(make_event(CMD_MSG, NO_DATA, 0, 0, 0), 1,
			typed_result(ST_BUSY, 0, 0, 0, NO_DATA, 0));
		add_row(make_event(CMD_TIMEOUT, random_frame(), $urandom, $urandom, $urandom), 1,
			typed_result(ST_RESENT, 1, 0, 5100, ALL_ONES, 0));
		// Intact acks with the wrong number, including one whose low bit looks right.
		add_row(make_event(CMD_ACK, NO_DATA, 0, 1, 1), 1,
			typed_result(ST_UNEXPECTED, 0, 0, 0, NO_DATA, 0));
		add_row(make_event(CMD_ACK, NO_DATA, 0, 32'h100, 1), 1,
			typed_result(ST_UNEXPECTED, 0, 0, 0, NO_DATA, 0));
		add_row(with_checksum(make_event(CMD_ACK, NO_DATA, 32'h7FFF_FFFF, 0, 0)), 0, '0);
		add_row(make_event(CMD_ACK, NO_DATA, 0, 0, 0), 1,
			typed_result(ST_UNEXPECTED, 0, 0, 0, NO_DATA, 0));
		add_row(make_event(CMD_TIMEOUT, NO_DATA, 0, 0, 0), 0, '0);
		add_row(make_event(CMD_MSG, NO_DATA, $urandom, $urandom, $urandom), 1,
			typed_result(ST_SENT, 1, 1, 1, NO_DATA, 0));
		add_row(make_event(CMD_ACK, NO_DATA, 0, 0, 0), 1,
			typed_result(ST_UNEXPECTED, 0, 0, 0, NO_DATA, 0));
		add_row(make_event(CMD_ACK, ALL_ONES, 0, 1, 32'h8000_0000), 1,
			typed_result(ST_CORRUPT, 0, 0, 0, NO_DATA, 0));
		add_row(make_event(CMD_ACK, ALL_ONES, 0, 1, 32'h7FFF_FFFF), 1,
			typed_result(ST_CORRUPT, 0, 0, 0, NO_DATA, 0));
		add_row(make_event(CMD_ACK, ALL_ONES, 32'hFFFF_FFFF, 1, 6121), 1,
			typed_result(ST_ACCEPTED, 0, 0, 0, NO_DATA, 1));
		add_row(make_event(CMD_MSG, random_frame(), $urandom, $urandom, $urandom), 0, '0);
		add_row(make_event(CMD_NONE, random_frame(), $urandom, $urandom, $urandom), 0, '0);
		add_row(with_checksum(make_event(CMD_ACK, random_frame(), 32'h8000_0000, 0, 0)), 0, '0);
		add_row(make_event(CMD_MSG, random_frame(), $urandom, $urandom, $urandom), 0, '0);
		add_row(make_event(CMD_TIMEOUT, random_frame(), $urandom, $urandom, $urandom), 0, '0);

		foreach (directed_rows[i])
			send_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].want);
		directed_answered = events_answered;

		while (events_answered < directed_answered + RANDOM_EVENTS) begin
			n = events_answered - directed_answered;
			if (n < RANDOM_EVENTS / 4) begin
				send_idle_pct = 0;
				stall_pct     = 0;
			end else if (n < RANDOM_EVENTS / 2) begin
				send_idle_pct = 58;
				stall_pct     = 0;
			end else if (n < 3 * RANDOM_EVENTS / 4) begin
				send_idle_pct = 0;
				stall_pct     = 58;
			end else begin
				send_idle_pct = 30;
				stall_pct     = 30;
			end
			// Once, let every outstanding result come back before going on.
			if (!held_off && n >= RANDOM_EVENTS / 2) begin
				held_off = 1'b1;
				drain_results();
			end
			send_word(random_event(), 0, '0);
		end

		drain_results();
		$display("Ran %0d answered event words (%0d from the directed table) under four idle mixes;",
			events_answered, directed_answered);
		$display("the sender accepted %0d acks and resent %0d packets.", acks_accepted, resends);
		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule
